// File: hdl/kb64_pkg.sv
// Shared types, constants and the alphabet lookup of the keyed base64 encoder.
// Used by every module under hdl; depends on nothing.
package kb64_pkg;

  localparam int unsigned ALPHA_LEN   = 64;
  localparam int unsigned NUM_DICTS   = 4;
  localparam int unsigned SLOTS       = 4;
  localparam int unsigned JOB_DEPTH   = 2;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Register indexes, taken from paddr[2].
  localparam logic REG_DICT = 1'b0;
  localparam logic REG_ROT  = 1'b1;

  // Group positions inside a 3-byte group.
  localparam logic [1:0] POS_ZERO = 2'd0;
  localparam logic [1:0] POS_ONE  = 2'd1;
  localparam logic [1:0] POS_TWO  = 2'd2;

  localparam logic [8*ALPHA_LEN-1:0] ALPHABETS [NUM_DICTS] = '{
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/",
    "AaBbCcDdEeFfGgHhIiJjKkLlMmNnOoPpQqRrSsTtUuVvWwXxYyZz0123456789+/",
    "A1B2C3D4E5F6G7H8I9J0KLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+/",
    "0aA1bB2cC3dD4eE5fF6gG7hH8iI9jJkKlLmMnNoOpPqQrRsStTuUvVwWxXyYzZ+/"
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic [1:0] dictionary_select;
    logic [5:0] rotation;
  } cfg_t;

  // One character to produce: a sextet or a pad.
  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } slot_t;

  // Characters caused by one input byte.
  typedef struct packed {
    slot_t [SLOTS-1:0] slots;
    logic [1:0]        last_idx;
    logic              is_last;
  } job_t;

  // String literals put the first character in the top byte.
  function automatic logic [7:0] alpha_char(logic [1:0] dict, logic [5:0] idx);
    logic [8*ALPHA_LEN-1:0] row;
    row = ALPHABETS[dict];
    return row[8*(ALPHA_LEN-1-int'(idx)) +: 8];
  endfunction

endpackage

// File: hdl/kb64_regs.sv
// APB-style configuration registers: alphabet select and rotation.
// Depends on kb64_pkg.
module kb64_regs
  import kb64_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_DICT: cfg_d.dictionary_select = pwdata[1:0];
        REG_ROT:  cfg_d.rotation          = pwdata[5:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DICT: prdata = {{(PDATA_W-2){1'b0}}, cfg_q.dictionary_select};
      REG_ROT:  prdata = {{(PDATA_W-6){1'b0}}, cfg_q.rotation};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/kb64_front.sv
// Front end: accepts bytes, tracks the 3-byte group and splits each byte
// into a job of sextets and pads. Depends on kb64_pkg.
module kb64_front
  import kb64_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_item_t item_i,
  output job_t     job_o
);

  logic [1:0] pos_q, pos_d;
  logic [3:0] lo_q, lo_d;
  logic [7:0] b;
  logic       last;

  assign b    = item_i.data_byte;
  assign last = item_i.last_byte;

  always_comb begin
    job_o         = '0;
    job_o.is_last = last;
    pos_d         = pos_q;
    lo_d          = lo_q;
    unique case (pos_q)
      POS_ONE: begin
        job_o.slots[0].sextet = {lo_q[1:0], b[7:4]};
        job_o.slots[1].sextet = {b[3:0], 2'b00};
        job_o.slots[2].pad    = 1'b1;
        job_o.last_idx        = last ? 2'd2 : 2'd0;
        pos_d                 = POS_TWO;
        lo_d                  = b[3:0];
      end
      POS_TWO: begin
        job_o.slots[0].sextet = {lo_q, b[7:6]};
        job_o.slots[1].sextet = b[5:0];
        job_o.last_idx        = 2'd1;
        pos_d                 = POS_ZERO;
        lo_d                  = 4'd0;
      end
      default: begin
        // Position three never occurs; treat it as the group start.
        job_o.slots[0].sextet = b[7:2];
        job_o.slots[1].sextet = {b[1:0], 4'b0000};
        job_o.slots[2].pad    = 1'b1;
        job_o.slots[3].pad    = 1'b1;
        job_o.last_idx        = last ? 2'd3 : 2'd0;
        pos_d                 = POS_ONE;
        lo_d                  = {2'b00, b[1:0]};
      end
    endcase
    if (last) begin
      pos_d = POS_ZERO;
      lo_d  = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_ZERO;
      lo_q  <= 4'd0;
    end else if (take_i) begin
      pos_q <= pos_d;
      lo_q  <= lo_d;
    end
  end

endmodule

// File: hdl/kb64_fifo.sv
// Small job queue between the front and back ends.
// Depends on kb64_pkg for the job type.
module kb64_fifo
  import kb64_pkg::*;
#(
  parameter int unsigned DEPTH = JOB_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wdata_i,
  input  logic rd_i,
  output job_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + PTR_W'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/kb64_back.sv
// Back end: walks the slots of each job, looks up one character per cycle
// while the output register is free or popped and holds it in that register. Depends on kb64_pkg.
module kb64_back
  import kb64_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  job_t      job_i,
  input  logic      job_empty_i,
  output logic      job_rd_o,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item_o
);

  job_t       cur_q;
  logic       cur_v_q;
  logic [1:0] idx_q;
  logic       out_v_q;
  out_item_t  out_q, out_d;
  logic       adv, emit, job_done;
  slot_t      slot;

  assign adv      = ~out_v_q | pop;
  assign emit     = adv & cur_v_q;
  assign job_done = emit & (idx_q == cur_q.last_idx);
  assign job_rd_o = ~job_empty_i & (~cur_v_q | job_done);
  assign slot     = cur_q.slots[idx_q];

  always_comb begin
    out_d.out_char  = slot.pad ? PAD_CHAR
                    : alpha_char(cfg_i.dictionary_select,
                                 6'(slot.sextet + cfg_i.rotation));
    out_d.last_char = cur_q.is_last & (idx_q == cur_q.last_idx);
  end

  always_ff @(posedge clk_i) begin
    if (job_rd_o) begin
      cur_q <= job_i;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= 2'd0;
      out_v_q <= 1'b0;
    end else begin
      if (job_rd_o) begin
        cur_v_q <= 1'b1;
        idx_q   <= 2'd0;
      end else if (job_done) begin
        cur_v_q <= 1'b0;
        idx_q   <= 2'd0;
      end else if (emit) begin
        idx_q   <= idx_q + 2'd1;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign empty      = ~out_v_q;
  assign out_item_o = out_q;

endmodule

// File: hdl/keyed_base64_encoder.sv
// Top level of the keyed base64 encoder: registers, front end, job queue
// and back end. Depends on kb64_pkg and the kb64_* modules.
//
//   channel   direction  handshake                 payload
//   input     in         push / full               in_item_i  (data_byte, last_byte)
//   result    out        empty / pop               out_item_o (out_char, last_char)
//   config    in/out     psel penable pwrite pready paddr, pwdata, prdata
//
// One character leaves per cycle while results are popped at once, so a byte
// gives one character (group start or middle), two (group end) or up to four
// (last byte): three bytes give four characters.
// The back end's single character lookup per cycle sets that rate.
// A byte's job passes the job queue and the back end's current-job register
// before its first character is held in the output register.
// A byte enters in the cycle it is offered unless the job queue is full;
// a stalled pop holds the output register and then fills the queue.
// Reset clears the group state, the queue, the back end and both registers.
module keyed_base64_encoder
  import kb64_pkg::*;
#(
  parameter int unsigned JobDepth = JOB_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_item_i,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  job_t job_in, job_out;
  logic take, job_empty, job_rd;

  // Accept a byte whenever the queue has room for its job.
  assign take = push & ~full;

  kb64_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Classify the byte by its group position and build its job.
  kb64_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_item_i),
    .job_o  (job_in)
  );

  // Decouple byte intake from character output.
  kb64_fifo #(
    .DEPTH (JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (take),
    .wdata_i (job_in),
    .rd_i    (job_rd),
    .rdata_o (job_out),
    .full_o  (full),
    .empty_o (job_empty)
  );

  // Emit characters one per cycle through the output register while it is free or popped.
  kb64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_rd_o    (job_rd),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hdl/kb64_checker.sv
// Port-level checks for the keyed base64 encoder, bound to the top level.
// Depends on kb64_pkg and keyed_base64_encoder.
module kb64_checker
  import kb64_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o,
  input logic      pready
);

  // Hold a stalled result.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("stalled result changed");

  // Pads come back to back up to the final character.
  a_pad_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_item_o.out_char == PAD_CHAR && !out_item_o.last_char)
    |=> (!empty && out_item_o.out_char == PAD_CHAR))
    else $error("pad run broken");

  // A new message never opens with a pad.
  a_no_lead_pad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_item_o.last_char)
    |=> (empty || out_item_o.out_char != PAD_CHAR))
    else $error("pad after final character");

  // Register access never waits.
  a_pready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind keyed_base64_encoder kb64_checker u_kb64_checker (.*);
